### rtl/core/smdc_pkg.sv
// ----------------------------------------------------------------------------
// smdc_pkg
// shared widths, defaults and types of the sliding median deviation core
// ----------------------------------------------------------------------------
package smdc_pkg;

  localparam int SAMPLE_W       = 32;
  localparam int COST_W         = 38;
  localparam int CFG_W          = 7;
  localparam int WINDOW_MAX_DEF = 64;

  localparam logic [CFG_W-1:0] WINDOW_LEN_RST = CFG_W'(3);

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic upd;       // load the re-sorted value
    logic shift;     // move the drain copy one cell toward the head
    logic del_mode;  // window full: drop the oldest sample on update
  } cell_ctl_t;

endpackage

### rtl/core/smdc_ring.sv
// ----------------------------------------------------------------------------
// smdc_ring
// arrival-order history, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module smdc_ring #(
  parameter int DEPTH = smdc_pkg::WINDOW_MAX_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [AW-1:0]     addr_i,
  input  smdc_pkg::sample_t wdata_i,
  output smdc_pkg::sample_t rdata_o
);

  smdc_pkg::sample_t mem_q [DEPTH];
  smdc_pkg::sample_t rdata_q;

  // read returns the old word when the same slot is written
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/smdc_cell.sv
// ----------------------------------------------------------------------------
// smdc_cell
// one slot of the sorted window with its drain copy for the cost pass
// ----------------------------------------------------------------------------
module smdc_cell #(
  parameter int IDX   = 0,
  parameter int CNT_W = 7
) (
  input  logic                clk_i,
  input  smdc_pkg::cell_ctl_t ctl_i,
  input  smdc_pkg::sample_t   sample_i,
  input  smdc_pkg::sample_t   del_val_i,
  input  logic [CNT_W-1:0]    keep_cnt_i,
  input  smdc_pkg::sample_t   val_next_i,
  input  smdc_pkg::sample_t   w_prev_i,
  input  logic                lw_prev_i,
  input  smdc_pkg::sample_t   drn_next_i,
  output smdc_pkg::sample_t   val_o,
  output smdc_pkg::sample_t   w_o,
  output logic                lw_o,
  output smdc_pkg::sample_t   drn_o
);

  smdc_pkg::sample_t val_q;
  smdc_pkg::sample_t drn_q;
  smdc_pkg::sample_t upd_val;
  logic              at_or_past_del;
  logic              keep_valid;

  // after removal of the first copy of the leaving word, slot takes its right neighbor
  assign at_or_past_del = (val_q >= del_val_i);
  assign w_o            = (ctl_i.del_mode && at_or_past_del) ? val_next_i : val_q;
  assign keep_valid     = (CNT_W'(IDX) < keep_cnt_i);
  assign lw_o           = keep_valid && (w_o <= sample_i);

  // new word goes behind every kept word that is not greater
  assign upd_val = lw_o ? w_o : (lw_prev_i ? sample_i : w_prev_i);

  always_ff @(posedge clk_i) begin
    if (ctl_i.upd) begin
      val_q <= upd_val;
      drn_q <= upd_val;
    end else if (ctl_i.shift) begin
      drn_q <= drn_next_i;
    end
  end

  assign val_o = val_q;
  assign drn_o = drn_q;

endmodule

### rtl/core/sliding_median_deviation_cost_core.sv
// ----------------------------------------------------------------------------
// sliding_median_deviation_cost_core
// sliding window median and sum of absolute deviations from it
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+------------------------------
//  in      | input     | in_valid_i/in_ready_o  | in_sample_i (32b signed)
//  out     | output    | out_valid_o/out_ready_i| out_median_value_o (32b signed)
//          |           |                        | out_deviation_cost_o (38b)
//  cfg     | input     | cfg_valid_i/cfg_ready_o| cfg_window_len_i (7b)
//
//  a word that leaves the window unfilled passes through accept and re-sort
//  a word that yields a result passes through accept, re-sort, a sum step
//    per window slot as the drain chain walks the sorted words past the adder,
//    and a finish step that loads the output register
//  the finish step holds while the output register is full and not taken;
//    a new word is accepted while an earlier result waits
//  reset clears control only; sorted cells and history need no clearing pass
//  a window length write empties the window and goes ahead of a word offered
//    in the same cycle
//
module sliding_median_deviation_cost_core #(
  parameter int WINDOW_MAX = smdc_pkg::WINDOW_MAX_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic signed [smdc_pkg::SAMPLE_W-1:0] in_sample_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [smdc_pkg::SAMPLE_W-1:0] out_median_value_o,
  output logic [smdc_pkg::COST_W-1:0]       out_deviation_cost_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [smdc_pkg::CFG_W-1:0]        cfg_window_len_i
);

  localparam int PTR_W = $clog2(WINDOW_MAX);
  localparam int LEN_W = $clog2(WINDOW_MAX + 1);
  localparam int CMP_W = (LEN_W > smdc_pkg::CFG_W) ? LEN_W : smdc_pkg::CFG_W;
  // sum of window words with signs, plus headroom
  localparam int ACC_W = smdc_pkg::SAMPLE_W + $clog2(WINDOW_MAX) + 2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_UPD,
    S_SUM,
    S_FIN
  } state_e;

  state_e                         state_q, state_d;
  logic [smdc_pkg::CFG_W-1:0]     wlen_q, wlen_d;
  logic [LEN_W-1:0]               fill_q, fill_d;
  logic [PTR_W-1:0]               ptr_q, ptr_d;
  logic [LEN_W-1:0]               k_q, k_d;
  logic signed [ACC_W-1:0]        acc_q, acc_d;
  smdc_pkg::sample_t              sample_q, sample_d;
  smdc_pkg::sample_t              med_q, med_d;
  logic                           out_valid_q, out_valid_d;
  smdc_pkg::sample_t              out_med_q, out_med_d;
  logic [smdc_pkg::COST_W-1:0]    out_cost_q, out_cost_d;

  logic [LEN_W-1:0]               len;
  logic [LEN_W-1:0]               mid;
  logic [LEN_W-1:0]               ptr_inc;
  logic [LEN_W-1:0]               keep_cnt;
  logic                           full;
  logic                           in_acc;
  logic                           cfg_acc;
  logic signed [ACC_W-1:0]        head_x;
  logic signed [ACC_W-1:0]        cost_fin;
  smdc_pkg::sample_t              old_word;
  smdc_pkg::cell_ctl_t            ctl;

  smdc_pkg::sample_t              val_w [WINDOW_MAX];
  smdc_pkg::sample_t              w_w   [WINDOW_MAX];
  logic                           lw_w  [WINDOW_MAX];
  smdc_pkg::sample_t              drn_w [WINDOW_MAX];

  // effective window length: zero acts as one, clipped at the cell count
  always_comb begin
    if (wlen_q == '0) begin
      len = LEN_W'(1);
    end else if (CMP_W'(wlen_q) > CMP_W'(WINDOW_MAX)) begin
      len = LEN_W'(WINDOW_MAX);
    end else begin
      len = LEN_W'(wlen_q);
    end
  end

  assign mid      = len >> 1;
  assign full     = (fill_q == len);
  assign keep_cnt = full ? (len - LEN_W'(1)) : fill_q;
  assign ptr_inc  = LEN_W'(ptr_q) + LEN_W'(1);

  // a pending length write keeps the sample word waiting
  assign in_ready_o  = (state_q == S_IDLE) && !cfg_valid_i;
  assign cfg_ready_o = (state_q == S_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign cfg_acc     = cfg_valid_i && cfg_ready_o;

  // history slot at the pointer holds the oldest word once the window is full
  smdc_ring #(
    .DEPTH (WINDOW_MAX),
    .AW    (PTR_W)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (in_acc),
    .addr_i  (ptr_q),
    .wdata_i (in_sample_i),
    .rdata_o (old_word)
  );

  assign ctl.upd      = (state_q == S_UPD);
  assign ctl.shift    = (state_q == S_SUM);
  assign ctl.del_mode = full;

  // sorted chain, slot 0 holds the smallest word; drain copies flow toward slot 0
  for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
    smdc_pkg::sample_t nxt_val;
    smdc_pkg::sample_t nxt_drn;
    smdc_pkg::sample_t prv_w;
    logic              prv_lw;

    if (i == WINDOW_MAX - 1) begin : g_tail
      assign nxt_val = '0;
      assign nxt_drn = '0;
    end else begin : g_mid
      assign nxt_val = val_w[i+1];
      assign nxt_drn = drn_w[i+1];
    end

    if (i == 0) begin : g_head
      assign prv_w  = '0;
      assign prv_lw = 1'b1;
    end else begin : g_body
      assign prv_w  = w_w[i-1];
      assign prv_lw = lw_w[i-1];
    end

    smdc_cell #(
      .IDX   (i),
      .CNT_W (LEN_W)
    ) u_cell (
      .clk_i      (clk_i),
      .ctl_i      (ctl),
      .sample_i   (sample_q),
      .del_val_i  (old_word),
      .keep_cnt_i (keep_cnt),
      .val_next_i (nxt_val),
      .w_prev_i   (prv_w),
      .lw_prev_i  (prv_lw),
      .drn_next_i (nxt_drn),
      .val_o      (val_w[i]),
      .w_o        (w_w[i]),
      .lw_o       (lw_w[i]),
      .drn_o      (drn_w[i])
    );
  end

  // lower half counts negative, upper half positive; an odd window also
  // subtracts the median once, which leaves the sum of absolute deviations
  assign head_x   = ACC_W'(drn_w[0]);
  assign cost_fin = acc_q - (len[0] ? ACC_W'(med_q) : '0);

  always_comb begin
    state_d     = state_q;
    wlen_d      = wlen_q;
    fill_d      = fill_q;
    ptr_d       = ptr_q;
    k_d         = k_q;
    acc_d       = acc_q;
    sample_d    = sample_q;
    med_d       = med_q;
    out_valid_d = out_valid_q;
    out_med_d   = out_med_q;
    out_cost_d  = out_cost_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          sample_d = in_sample_i;
          ptr_d    = (ptr_inc == len) ? '0 : ptr_inc[PTR_W-1:0];
          state_d  = S_UPD;
        end
      end
      S_UPD: begin
        k_d   = '0;
        acc_d = '0;
        if (!full) begin
          fill_d = fill_q + LEN_W'(1);
        end
        if (full || (fill_q + LEN_W'(1) == len)) begin
          state_d = S_SUM;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_SUM: begin
        acc_d = (k_q < mid) ? (acc_q - head_x) : (acc_q + head_x);
        if (k_q == mid) begin
          med_d = drn_w[0];
        end
        if (k_q == len - LEN_W'(1)) begin
          state_d = S_FIN;
        end else begin
          k_d = k_q + LEN_W'(1);
        end
      end
      S_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_med_d   = med_q;
          out_cost_d  = smdc_pkg::COST_W'($unsigned(cost_fin));
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // a new length empties the window
    if (cfg_acc) begin
      wlen_d = cfg_window_len_i;
      fill_d = '0;
      ptr_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      wlen_q      <= smdc_pkg::WINDOW_LEN_RST;
      fill_q      <= '0;
      ptr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wlen_q      <= wlen_d;
      fill_q      <= fill_d;
      ptr_q       <= ptr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q        <= k_d;
    acc_q      <= acc_d;
    sample_q   <= sample_d;
    med_q      <= med_d;
    out_med_q  <= out_med_d;
    out_cost_q <= out_cost_d;
  end

  assign out_valid_o          = out_valid_q;
  assign out_median_value_o   = out_med_q;
  assign out_deviation_cost_o = out_cost_q;

`ifndef ASSERT_OFF
  a_fill_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= len)
    else $error("fill count above window length");

  a_ptr_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    LEN_W'(ptr_q) < len)
    else $error("ring pointer outside window");

  a_sum_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SUM) |-> (k_q < len) && full)
    else $error("cost pass out of range");

  a_cfg_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_acc |=> (fill_q == '0) && (ptr_q == '0))
    else $error("length write did not empty window");

  a_fin_load : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIN) && (!out_valid_q || out_ready_i) |=> out_valid_q)
    else $error("finished result not loaded");
`endif

endmodule
